FILE: src/btf_pkg.sv
// shared types, constants and crc helper for the battery telemetry framer
package btf_pkg;

  localparam int unsigned TimeW       = 32;
  localparam int unsigned MvW         = 16;
  localparam int unsigned DvW         = 10;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned FrameLen    = 12;
  localparam int unsigned IdxW        = $clog2(FrameLen);
  localparam int unsigned QueueDepth  = 2;

  localparam logic [TimeW-1:0] IntervalReset = TimeW'(1000);

  localparam logic [ByteW-1:0] AddrByte = 8'hC8;
  localparam logic [ByteW-1:0] LenByte  = 8'd10;
  localparam logic [ByteW-1:0] TypeByte = 8'h08;
  localparam logic [ByteW-1:0] CrcPoly  = 8'hD5;

  localparam logic [IdxW-1:0] IdxAddr    = IdxW'(0);
  localparam logic [IdxW-1:0] IdxLen     = IdxW'(1);
  localparam logic [IdxW-1:0] IdxType    = IdxW'(2);
  localparam logic [IdxW-1:0] IdxVoltHi  = IdxW'(3);
  localparam logic [IdxW-1:0] IdxVoltLo  = IdxW'(4);
  localparam logic [IdxW-1:0] IdxCrc     = IdxW'(FrameLen - 1);

  // rounding offset and reciprocal of 100 for millivolt to decivolt scaling
  localparam int unsigned RoundOfs  = 50;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW    = 18;
  localparam logic [RecipW-1:0] Recip100 = RecipW'(((1 << RecipShift) + 99) / 100);

  typedef logic [DvW-1:0] dv_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      if (c[ByteW-1]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/btf_front.sv
// tick intake: interval check, send-time register and decivolt scaling
module btf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [btf_pkg::TimeW-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [btf_pkg::TimeW-1:0]     now_ms,
  input  logic                          reading_valid,
  input  logic [btf_pkg::MvW-1:0]       voltage_mv,
  input  btf_pkg::q_status_t            q_status,
  output logic                          push,
  output btf_pkg::dv_t                  push_dv
);

  localparam int unsigned SumW  = btf_pkg::MvW + 1;
  localparam int unsigned ProdW = SumW + btf_pkg::RecipW;

  logic [btf_pkg::TimeW-1:0] send_interval_ms;
  logic [btf_pkg::TimeW-1:0] last_sent_ms;
  logic [btf_pkg::TimeW-1:0] elapsed;
  logic [SumW-1:0]           mv_rounded;
  logic [ProdW-1:0]          prod;
  logic                      send;
  logic                      accept;

  assign in_ready   = !q_status.full;
  assign accept     = in_valid && in_ready;
  assign elapsed    = now_ms - last_sent_ms;
  assign send       = reading_valid && (elapsed >= send_interval_ms);
  assign push       = accept && send;

  // divide by 100 as multiply by reciprocal, exact over the input range
  assign mv_rounded = SumW'(voltage_mv) + SumW'(btf_pkg::RoundOfs);
  assign prod       = ProdW'(mv_rounded) * ProdW'(btf_pkg::Recip100);
  assign push_dv    = prod[btf_pkg::RecipShift +: btf_pkg::DvW];

  always_ff @(posedge clk) begin
    if (rst) begin
      send_interval_ms <= btf_pkg::IntervalReset;
      last_sent_ms     <= '0;
    end else begin
      if (cfg_we) begin
        send_interval_ms <= cfg_wdata;
      end
      if (push) begin
        last_sent_ms <= now_ms;
      end
    end
  end

endmodule

FILE: src/btf_queue.sv
// small fifo of pending frame voltages between intake and serialiser
module btf_queue #(
  parameter int unsigned DEPTH = btf_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  btf_pkg::dv_t       push_dv,
  input  logic               pop,
  output btf_pkg::dv_t       head_dv,
  output btf_pkg::q_status_t status
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  btf_pkg::dv_t    entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);
  assign head_dv      = entries[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/btf_back.sv
// frame serialiser: emits one byte per word with a running crc
module btf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  btf_pkg::q_status_t        q_status,
  input  btf_pkg::dv_t              head_dv,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [btf_pkg::ByteW-1:0] frame_byte,
  output logic                      last_byte
);

  logic                      busy;
  logic [btf_pkg::IdxW-1:0]  idx;
  btf_pkg::dv_t              dv;
  logic [btf_pkg::ByteW-1:0] crc;
  logic                      advance;
  logic                      at_last;

  assign out_valid = busy;
  assign at_last   = (idx == btf_pkg::IdxCrc);
  assign last_byte = at_last;
  assign advance   = busy && out_ready;
  assign pop       = !q_status.empty && (!busy || (advance && at_last));

  always_comb begin
    case (idx)
      btf_pkg::IdxAddr:   frame_byte = btf_pkg::AddrByte;
      btf_pkg::IdxLen:    frame_byte = btf_pkg::LenByte;
      btf_pkg::IdxType:   frame_byte = btf_pkg::TypeByte;
      btf_pkg::IdxVoltHi: frame_byte = btf_pkg::ByteW'(dv >> btf_pkg::ByteW);
      btf_pkg::IdxVoltLo: frame_byte = dv[btf_pkg::ByteW-1:0];
      btf_pkg::IdxCrc:    frame_byte = crc;
      default:            frame_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (advance) begin
        idx <= idx + 1'b1;
        if (idx >= btf_pkg::IdxType) begin
          crc <= btf_pkg::crc8_step(crc, frame_byte);
        end
        if (at_last) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
        crc  <= '0;
        dv   <= head_dv;
      end
    end
  end

endmodule

FILE: src/battery_telemetry_framer.sv
// top level of the battery telemetry framer
//
// input channel (in_valid/in_ready) takes one time tick per word: now_ms,
// reading_valid and voltage_mv. a tick with a valid reading whose elapsed
// time since the last sent frame reaches send_interval_ms records now_ms as
// the new send time and queues one frame; any other tick is consumed silently.
// output channel (out_valid/out_ready) gives the 12 frame bytes in order,
// last_byte high on the crc byte.
// a frame is written into the queue, then loaded by the idle serialiser.
// throughput: one output byte per cycle while a frame is being sent and
// out_ready is high; ticks are taken one per cycle while the pending-frame
// queue (QUEUE_DEPTH frames) has room, which the serialiser drains one frame
// per 12 bytes.
// send_interval_ms is written through cfg_we/cfg_wdata, no read-back.
// reset clears the queue, the serialiser and the last send time and sets
// the interval to 1000 ms.
// a stalled receiver holds the current byte steady; intake keeps running
// until the queue fills, then in_ready drops.
module battery_telemetry_framer #(
  parameter int unsigned QUEUE_DEPTH = btf_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [btf_pkg::TimeW-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [btf_pkg::TimeW-1:0] now_ms,
  input  logic                      reading_valid,
  input  logic [btf_pkg::MvW-1:0]   voltage_mv,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [btf_pkg::ByteW-1:0] frame_byte,
  output logic                      last_byte
);

  btf_pkg::q_status_t q_status;
  btf_pkg::dv_t       push_dv;
  btf_pkg::dv_t       head_dv;
  logic               push;
  logic               pop;

  btf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .reading_valid (reading_valid),
    .voltage_mv    (voltage_mv),
    .q_status      (q_status),
    .push          (push),
    .push_dv       (push_dv)
  );

  btf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_dv (push_dv),
    .pop     (pop),
    .head_dv (head_dv),
    .status  (q_status)
  );

  btf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head_dv    (head_dv),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

FILE: src/btf_checker.sv
// port-level checks for the battery telemetry framer, bound to the top level
module btf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [btf_pkg::ByteW-1:0] frame_byte,
  input logic                      last_byte
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("stalled output word changed");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=> out_valid)
    else $error("frame broken off before crc byte");

  a_next_frame_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte |=>
      !out_valid || (frame_byte == btf_pkg::AddrByte && !last_byte))
    else $error("frame does not start with address byte");

endmodule

bind battery_telemetry_framer btf_checker u_btf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .frame_byte (frame_byte),
  .last_byte  (last_byte)
);

FILE: tb/btf_frame_checker.sv
// checker for the battery telemetry framer: predicts each frame and compares every output word
`timescale 1ns / 1ps

module btf_frame_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [btf_pkg::TimeW-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [btf_pkg::TimeW-1:0] now_ms,
  input  logic                      reading_valid,
  input  logic [btf_pkg::MvW-1:0]   voltage_mv,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [btf_pkg::ByteW-1:0] frame_byte,
  input  logic                      last_byte,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [btf_pkg::ByteW-1:0] data;
    logic                      tail;
  } frame_word_t;

  frame_word_t               bytes_due[$];
  logic [btf_pkg::TimeW-1:0] interval_ms;
  logic [btf_pkg::TimeW-1:0] last_send_ms;

  // bit-serial crc, msb first
  function automatic logic [btf_pkg::ByteW-1:0] crc_d5(
      input logic [btf_pkg::ByteW-1:0] acc,
      input logic [btf_pkg::ByteW-1:0] d);
    logic fb;
    for (int i = btf_pkg::ByteW - 1; i >= 0; i--) begin
      fb  = acc[btf_pkg::ByteW-1] ^ d[i];
      acc = {acc[btf_pkg::ByteW-2:0], 1'b0} ^ (fb ? btf_pkg::CrcPoly : '0);
    end
    return acc;
  endfunction

  task automatic queue_battery_frame(input logic [btf_pkg::MvW-1:0] mv);
    logic [btf_pkg::ByteW-1:0] frame [btf_pkg::FrameLen];
    logic [btf_pkg::MvW:0]     dv;
    logic [btf_pkg::ByteW-1:0] crc;
    dv = ({1'b0, mv} + (btf_pkg::MvW + 1)'(btf_pkg::RoundOfs)) / (btf_pkg::MvW + 1)'(100);
    frame[0] = btf_pkg::AddrByte;
    frame[1] = btf_pkg::LenByte;
    frame[2] = btf_pkg::TypeByte;
    frame[3] = dv[15:8];
    frame[4] = dv[7:0];
    for (int i = 5; i < btf_pkg::FrameLen; i++) frame[i] = '0;
    crc = '0;
    for (int i = 2; i < btf_pkg::FrameLen - 1; i++) crc = crc_d5(crc, frame[i]);
    frame[btf_pkg::FrameLen-1] = crc;
    for (int i = 0; i < btf_pkg::FrameLen; i++) begin
      bytes_due.push_back('{data: frame[i], tail: (i == btf_pkg::FrameLen - 1)});
    end
  endtask

  always @(posedge clk) begin : watch
    frame_word_t want;
    if (rst) begin
      interval_ms  = btf_pkg::IntervalReset;
      last_send_ms = '0;
      bytes_due.delete();
      fail_count   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          fail_count++;
          $error("frame_byte: no word expected, got %02h (last_byte %0b)",
                 frame_byte, last_byte);
        end else begin
          want = bytes_due.pop_front();
          if (frame_byte !== want.data) begin
            fail_count++;
            $error("frame_byte: expected %02h, got %02h", want.data, frame_byte);
          end
          if (last_byte !== want.tail) begin
            fail_count++;
            $error("last_byte: expected %0b, got %0b", want.tail, last_byte);
          end
        end
      end
      // wrapping elapsed time against the interval
      if (in_valid && in_ready && reading_valid &&
          btf_pkg::TimeW'(now_ms - last_send_ms) >= interval_ms) begin
        last_send_ms = now_ms;
        queue_battery_frame(voltage_mv);
      end
      if (cfg_we) interval_ms = cfg_wdata;
    end
    pending = bytes_due.size();
  end

endmodule

FILE: tb/tb_battery_telemetry_framer.sv
// top of the battery telemetry framer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_battery_telemetry_framer;

  localparam int StallLimit = 2000;
  localparam int Settle     = 8;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [btf_pkg::TimeW-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [btf_pkg::TimeW-1:0] now_ms = '0;
  logic                      reading_valid = 1'b0;
  logic [btf_pkg::MvW-1:0]   voltage_mv = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [btf_pkg::ByteW-1:0] frame_byte;
  logic                      last_byte;
  int                        fail_count;
  int                        pending;
  bit                        idle_on = 1'b1;
  int                        quiet = 0;

  always #1 clk = ~clk;

  battery_telemetry_framer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .reading_valid (reading_valid),
    .voltage_mv    (voltage_mv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte)
  );

  btf_frame_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .reading_valid (reading_valid),
    .voltage_mv    (voltage_mv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == StallLimit) begin
      $display("battery_telemetry_framer regression: fail");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_tick(input logic [btf_pkg::TimeW-1:0] t, input logic rv,
                           input logic [btf_pkg::MvW-1:0] mv);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    now_ms        <= t;
    reading_valid <= rv;
    voltage_mv    <= mv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_frames;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic set_interval(input logic [btf_pkg::TimeW-1:0] iv);
    drain_frames();
    cfg_we    <= 1'b1;
    cfg_wdata <= iv;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [btf_pkg::TimeW-1:0] t;
    logic [btf_pkg::TimeW-1:0] iv;
    logic [btf_pkg::MvW-1:0]   mv;
    logic                      rv;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset interval, first send time zero
    send_tick(32'd999, 1'b1, 16'd0);
    send_tick(32'd1000, 1'b1, 16'd0);
    send_tick(32'd5000, 1'b0, 16'hFFFF);
    send_tick(32'd5000, 1'b1, 16'hFFFF);
    send_tick(32'd5999, 1'b1, 16'd49);
    send_tick(32'd6000, 1'b1, 16'd50);
    send_tick(32'hFFFF_FFFF, 1'b1, 16'd149);
    send_tick(32'd100, 1'b1, 16'd150);
    send_tick(32'd1000, 1'b1, 16'd151);

    // zero interval: every valid reading sends
    set_interval('0);
    send_tick(32'd1000, 1'b1, 16'd12345);
    send_tick(32'd1000, 1'b1, 16'hFFFE);
    send_tick(32'd7, 1'b0, 16'd0);
    send_tick(32'd7, 1'b1, 16'd1);

    // widest interval: only one step back in time sends
    set_interval('1);
    send_tick(32'd7, 1'b1, 16'd100);
    send_tick(32'd6, 1'b1, 16'd30000);
    send_tick(32'd5, 1'b1, 16'h8000);

    t = $urandom;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       iv = 32'd7;
        1:       iv = '0;
        2:       iv = $urandom_range(1, 100);
        3:       iv = 32'h8000_0000;
        default: iv = btf_pkg::IntervalReset;
      endcase
      if (p == 4) idle_on = 1'b0;
      set_interval(iv);
      repeat (19) begin
        if (iv > 32'd100000 || $urandom_range(0, 9) == 0) begin
          t = $urandom;
        end else begin
          t = t + $urandom_range(0, 2 * iv + 1);
        end
        rv = ($urandom_range(0, 6) != 0);
        case ($urandom_range(0, 7))
          0:       mv = '0;
          1:       mv = '1;
          default: mv = btf_pkg::MvW'($urandom);
        endcase
        send_tick(t, rv, mv);
      end
    end

    drain_frames();
    if (fail_count == 0) begin
      $display("battery_telemetry_framer regression: pass");
    end else begin
      $display("battery_telemetry_framer regression: fail");
    end
    $finish;
  end

endmodule
